/* hdl/acc_pkg.sv */
package acc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_LSB_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_SCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_Z    = 3'd6;

  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned CENTER_W  = 16;
  localparam int unsigned GRAVITY_W = 12;
  localparam int unsigned CCOUNT_W  = 11;
  localparam int unsigned DBAND_W   = 15;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned G_W     = 18;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned MUL_A_W = 25;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned FRAC_W  = 12;

  localparam logic signed [31:0] ONE_G = 32'sd4096;

  typedef logic signed [G_W-1:0]   g_t;
  typedef logic signed [OUT_W-1:0] out_t;

  localparam g_t G_MAX = 18'sd131071;
  localparam g_t G_MIN = -18'sd131072;

  function automatic g_t clamp_g(input logic signed [31:0] v);
    g_t r;
    if (v > 32'sd131071) begin
      r = G_MAX;
    end else if (v < -32'sd131072) begin
      r = G_MIN;
    end else begin
      r = v[G_W-1:0];
    end
    return r;
  endfunction

  function automatic out_t sat_out(input logic signed [31:0] v);
    out_t r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/acc_div.sv */
module acc_div #(
  parameter int unsigned DVD_W = 29,
  parameter int unsigned DVS_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  a_q;
  logic [DVS_W-1:0]  rem_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    rem_nxt;
  logic              ge;

  // Restoring division, one quotient bit per cycle; the divisor is held by the caller.
  assign trial   = {rem_q, a_q[DVD_W-1]};
  assign ge      = trial >= {1'b0, divisor_i};
  assign rem_nxt = ge ? (trial - {1'b0, divisor_i}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= STEP_W'(DVD_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - STEP_W'(1);
        done_q <= (cnt_q == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      a_q   <= {a_q[DVD_W-2:0], ge};
      rem_q <= rem_nxt[DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = a_q;

endmodule

/* hdl/accel_calibrate_convert.sv */
// Measurement item: for each axis in turn the states MUL1, GVAL, MUL2 and SCALE, then OUT
// issues the result. Calibration item that does not complete the count: MUL1 and GVAL per
// axis, then CNT, no result. Completing calibration item: after CNT, the bit-serial divider
// averages each axis sum in turn (DSTART, DWAIT), then OUT. No new item is taken until IDLE.
// A stalled result holds the block until it is taken. One shared multiplier serves both multiplies.
// Reset (asynchronous, active low) restores register defaults, clears sums, count and offsets.
module accel_calibrate_convert #(
  parameter int unsigned ADC_BITS  = 12,
  parameter int unsigned CALIB_MAX = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [acc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [acc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [ADC_BITS-1:0]             raw_x_i,
  input  logic [ADC_BITS-1:0]             raw_y_i,
  input  logic [ADC_BITS-1:0]             raw_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            calib_done_o,
  output logic signed [acc_pkg::OUT_W-1:0] accel_x_o,
  output logic signed [acc_pkg::OUT_W-1:0] accel_y_o,
  output logic signed [acc_pkg::OUT_W-1:0] accel_z_o
);

  import acc_pkg::*;

  localparam int unsigned CNT_W = $clog2(CALIB_MAX + 1);
  localparam int unsigned SUM_W = G_W + 1 + $clog2(CALIB_MAX);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL1   = 4'd1;
  localparam logic [3:0] S_GVAL   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_SCALE  = 4'd4;
  localparam logic [3:0] S_CNT    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Z = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] axis_q;
  logic       mode_q;

  logic [GAIN_W-1:0]    lsb_gain_q;
  logic [CENTER_W-1:0]  center_q;
  logic [GRAVITY_W-1:0] gravity_q;
  logic [CCOUNT_W-1:0]  calib_count_q;
  logic [DBAND_W-1:0]   dband_q [3];

  logic signed [SUM_W-1:0] sum_q [3];
  g_t                      offset_q [3];
  logic [CNT_W-1:0]        seen_q;
  logic [CNT_W-1:0]        seen_inc;
  logic [CNT_W-1:0]        dvs_q;
  logic [CNT_W-1:0]        need;

  logic [CODE_W-1:0]        raw_q [3];
  logic signed [PROD_W-1:0] p_q;
  g_t                       g_q;
  out_t                     res_q [3];

  logic                calib_done_q;
  out_t                accel_q [3];
  logic                out_valid_q;
  logic                out_free;
  logic                in_accept;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [G_W:0]       diff;
  logic signed [31:0]        gv;
  g_t                        g_val;
  logic signed [31:0]        a32;
  logic signed [31:0]        db32;
  out_t                      meas_res;

  logic [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0] sum_abs;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] quot;
  logic [G_W-1:0]   quot_neg;
  g_t               offs;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign seen_inc = seen_q + CNT_W'(1);

  always_comb begin
    if (calib_count_q == '0) begin
      need = CNT_W'(1);
    end else if (32'(calib_count_q) > CALIB_MAX) begin
      need = CNT_W'(CALIB_MAX);
    end else begin
      need = CNT_W'(calib_count_q);
    end
  end

  // Shared multiplier: raw code times gain, or offset-corrected g times gravity scale.
  assign diff = (G_W+1)'(g_q) - (G_W+1)'(offset_q[axis_q]);
  always_comb begin
    if (state_q == S_MUL2) begin
      mul_a = MUL_A_W'(diff);
      mul_b = $signed(MUL_B_W'({1'b0, gravity_q}));
    end else begin
      mul_a = $signed({1'b0, lsb_gain_q});
      mul_b = $signed({1'b0, raw_q[axis_q]});
    end
  end
  assign prod = mul_a * mul_b;

  assign gv = $signed({4'b0, p_q[39:FRAC_W]}) - $signed({16'b0, center_q})
              - ((axis_q == AXIS_Z) ? ONE_G : 32'sd0);
  assign g_val = clamp_g(gv);

  assign a32  = 32'($signed(p_q[PROD_W-1:FRAC_W]));
  assign db32 = $signed({17'b0, dband_q[axis_q]});
  assign meas_res = ((a32 <= db32) && (a32 >= -db32)) ? '0 : sat_out(a32);

  assign sum_sel   = sum_q[axis_q];
  assign sum_abs   = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;
  assign div_start = (state_q == S_DSTART);
  assign quot_neg  = ~quot[G_W-1:0] + G_W'(1);

  always_comb begin
    if (sum_sel[SUM_W-1]) begin
      offs = (quot > SUM_W'(131072)) ? G_MIN : $signed(quot_neg);
    end else begin
      offs = (quot > SUM_W'(131071)) ? G_MAX : $signed(quot[G_W-1:0]);
    end
  end

  acc_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs),
    .divisor_i  (dvs_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_accept) state_d = S_MUL1;
      S_MUL1:   state_d = S_GVAL;
      S_GVAL: begin
        if (!mode_q) begin
          state_d = S_MUL2;
        end else if (axis_q == AXIS_Z) begin
          state_d = S_CNT;
        end else begin
          state_d = S_MUL1;
        end
      end
      S_MUL2:   state_d = S_SCALE;
      S_SCALE:  state_d = (axis_q == AXIS_Z) ? S_OUT : S_MUL1;
      S_CNT:    state_d = (seen_inc >= need) ? S_DSTART : S_IDLE;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) state_d = (axis_q == AXIS_Z) ? S_OUT : S_DSTART;
      end
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      axis_q        <= AXIS_X;
      mode_q        <= 1'b0;
      seen_q        <= '0;
      dvs_q         <= '0;
      out_valid_q   <= 1'b0;
      lsb_gain_q    <= 24'd45100;
      center_q      <= 16'd22528;
      gravity_q     <= 12'd2511;
      calib_count_q <= 11'd100;
      dband_q[0]    <= 15'd179;
      dband_q[1]    <= 15'd230;
      dband_q[2]    <= 15'd26;
      for (int i = 0; i < 3; i++) begin
        sum_q[i]    <= '0;
        offset_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LSB_GAIN:      lsb_gain_q    <= cfg_wdata_i;
          CFG_CENTER_LEVEL:  center_q      <= cfg_wdata_i[CENTER_W-1:0];
          CFG_GRAVITY_SCALE: gravity_q     <= cfg_wdata_i[GRAVITY_W-1:0];
          CFG_CALIB_COUNT:   calib_count_q <= cfg_wdata_i[CCOUNT_W-1:0];
          CFG_DEADBAND_X:    dband_q[0]    <= cfg_wdata_i[DBAND_W-1:0];
          CFG_DEADBAND_Y:    dband_q[1]    <= cfg_wdata_i[DBAND_W-1:0];
          CFG_DEADBAND_Z:    dband_q[2]    <= cfg_wdata_i[DBAND_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            mode_q <= mode_i;
            axis_q <= AXIS_X;
            if (!mode_i) begin
              seen_q <= '0;
              for (int i = 0; i < 3; i++) begin
                sum_q[i] <= '0;
              end
            end
          end
        end
        S_GVAL: begin
          if (mode_q) begin
            sum_q[axis_q] <= sum_q[axis_q] + SUM_W'(g_val);
            if (axis_q != AXIS_Z) axis_q <= axis_q + 2'd1;
          end
        end
        S_SCALE: begin
          if (axis_q != AXIS_Z) axis_q <= axis_q + 2'd1;
        end
        S_CNT: begin
          if (seen_inc >= need) begin
            dvs_q  <= seen_inc;
            seen_q <= '0;
            axis_q <= AXIS_X;
          end else begin
            seen_q <= seen_inc;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            offset_q[axis_q] <= offs;
            sum_q[axis_q]    <= '0;
            if (axis_q != AXIS_Z) axis_q <= axis_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q[0] <= CODE_W'(raw_x_i);
      raw_q[1] <= CODE_W'(raw_y_i);
      raw_q[2] <= CODE_W'(raw_z_i);
    end
    if (state_q == S_MUL1 || state_q == S_MUL2) begin
      p_q <= prod;
    end
    if (state_q == S_GVAL) begin
      g_q <= g_val;
    end
    if (state_q == S_SCALE) begin
      res_q[axis_q] <= meas_res;
    end
    if (state_q == S_DWAIT && div_done) begin
      res_q[axis_q] <= sat_out(32'(offs));
    end
    if (state_q == S_OUT && out_free) begin
      calib_done_q <= mode_q;
      accel_q[0]   <= res_q[0];
      accel_q[1]   <= res_q[1];
      accel_q[2]   <= res_q[2];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign calib_done_o = calib_done_q;
  assign accel_x_o    = accel_q[0];
  assign accel_y_o    = accel_q[1];
  assign accel_z_o    = accel_q[2];

`ifndef SYNTHESIS
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !$rose(out_valid_q))
    else $error("result appeared in the cycle after an item was taken");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DWAIT))
    else $error("divider finished outside the averaging step");

  a_calib_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && calib_done_q) |-> (seen_q == '0))
    else $error("calibration result issued with count not cleared");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (dvs_q != '0))
    else $error("divider started with a zero divisor");
`endif

endmodule
